// ----- hdl/priority_mux_with_timeouts_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority mux with timeouts
// Shorthand for clocked implications on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_MUX_WITH_TIMEOUTS_MACROS_SVH
`define PRIORITY_MUX_WITH_TIMEOUTS_MACROS_SVH

// Same-cycle implication.
`define PMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pmt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared widths, codes and reset values of the priority mux with timeouts.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int NUM_SOURCES   = 3;
  localparam int NUM_AXES      = 6;
  localparam int VEL_WIDTH     = 32;
  localparam int SRC_WIDTH     = 2;
  localparam int TIMEOUT_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 2;

  localparam int TDATA_WIDTH     = NUM_AXES * VEL_WIDTH;
  localparam int IN_TUSER_WIDTH  = 1 + SRC_WIDTH;   // command, source
  localparam int OUT_TUSER_WIDTH = SRC_WIDTH + 1;   // selected_source, selection_changed

  // Item kinds on in_tuser[0]
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MSG  = 1'b1;

  // Selection code meaning no source is active
  localparam logic [SRC_WIDTH-1:0] SRC_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SRC0_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SRC1_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SRC2_TIMEOUT = 2'd2;

  // Timeout reset values
  localparam logic [TIMEOUT_WIDTH-1:0] SRC0_TIMEOUT_RST = 16'd20;
  localparam logic [TIMEOUT_WIDTH-1:0] SRC1_TIMEOUT_RST = 16'd10;
  localparam logic [TIMEOUT_WIDTH-1:0] SRC2_TIMEOUT_RST = 16'd10;

  typedef logic [VEL_WIDTH-1:0] vel_t;
  typedef logic [TDATA_WIDTH-1:0] vel_vec_t;   // six axes, lin_x lowest

endpackage

// ----- hdl/priority_mux_with_timeouts.sv -----
// ----------------------------------------------------------------------------
// priority_mux_with_timeouts
// Fixed-priority velocity command mux with per-source watchdog timeouts.
// ----------------------------------------------------------------------------
// Three velocity command sources share one output; source 0 wins over 1, 1 over
// 2. A message item (in_tuser[0] = 1) stores the six Q16.16 velocities of the
// source in in_tuser[2:1], marks it seen and zeroes its age; messages from
// source code 3 are dropped and produce nothing. A tick item (in_tuser[0] = 0)
// picks the highest-priority seen source whose age, taken before this tick, is
// below its timeout register, and returns one item carrying that source's
// velocities, or zeros with source code 3 when nothing is active, plus a flag
// set when the pick differs from the previous tick's. All ages then advance by
// one and stick at all ones. Timing: one item per cycle, sustained while the
// output is not stalled. Each item is decoded, arbitrated and committed to the
// state and the output register in the cycle it is accepted, so the tick
// result appears on out_* in the next cycle and a following item already sees
// the updated state. in_tready is low only while a finished result sits in
// the output register and the consumer is stalling. Timeouts are written on
// the cfg_* port (index 0..2, index 3 is ignored) and should change only
// while the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module priority_mux_with_timeouts #(
  parameter int AGE_WIDTH = 16   // age counter width, 8..32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [0] command, [2:1] source
  input  logic [pmt_pkg::IN_TUSER_WIDTH-1:0]    in_tuser,
  // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, 32 bits each, from bit 0 up
  input  logic [pmt_pkg::TDATA_WIDTH-1:0]       in_tdata,

  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] selected_source, [2] selection_changed
  output logic [pmt_pkg::OUT_TUSER_WIDTH-1:0]   out_tuser,
  // out_lin_x .. out_ang_z, 32 bits each, from bit 0 up
  output logic [pmt_pkg::TDATA_WIDTH-1:0]       out_tdata,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pmt_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [pmt_pkg::TIMEOUT_WIDTH-1:0]     cfg_data
);

  import pmt_pkg::*;

  localparam int CMP_WIDTH = (AGE_WIDTH > TIMEOUT_WIDTH) ? AGE_WIDTH : TIMEOUT_WIDTH;

  // Per-source state
  vel_vec_t                 vel_r     [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]   seen_r;
  logic [AGE_WIDTH-1:0]     age_r     [NUM_SOURCES];
  logic [TIMEOUT_WIDTH-1:0] timeout_r [NUM_SOURCES];
  logic [SRC_WIDTH-1:0]     cur_sel_r;

  // Output register
  logic                       out_valid_r;
  logic [OUT_TUSER_WIDTH-1:0] out_tuser_r;
  vel_vec_t                   out_tdata_r;

  // Decode of the item on the input
  logic                 in_accept;
  logic                 is_tick;
  logic                 is_msg;
  logic [SRC_WIDTH-1:0] in_src;

  // Arbitration
  logic [NUM_SOURCES-1:0] active;
  logic [SRC_WIDTH-1:0]   pick;
  vel_vec_t               pick_vel;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign in_src    = in_tuser[SRC_WIDTH:1];
  assign is_tick   = in_accept && (in_tuser[0] == CMD_TICK);
  // source code 3 (and above) is not a real source: drop the message
  assign is_msg    = in_accept && (in_tuser[0] == CMD_MSG) &&
                     (CMP_WIDTH'(in_src) < CMP_WIDTH'(NUM_SOURCES));

  assign cfg_ready = 1'b1;

  // A source is live if it has spoken and its age has not reached its timeout.
  // Scanning from the lowest priority up leaves the highest-priority winner.
  always_comb begin
    pick     = SRC_NONE;
    pick_vel = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      active[i] = seen_r[i] && (CMP_WIDTH'(age_r[i]) < CMP_WIDTH'(timeout_r[i]));
      if (active[i]) begin
        pick     = SRC_WIDTH'(i);
        pick_vel = vel_r[i];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      cur_sel_r    <= SRC_NONE;
      out_valid_r  <= 1'b0;
      timeout_r[0] <= SRC0_TIMEOUT_RST;
      timeout_r[1] <= SRC1_TIMEOUT_RST;
      timeout_r[2] <= SRC2_TIMEOUT_RST;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SRC0_TIMEOUT: timeout_r[0] <= cfg_data;
          REG_SRC1_TIMEOUT: timeout_r[1] <= cfg_data;
          REG_SRC2_TIMEOUT: timeout_r[2] <= cfg_data;
          default: ;
        endcase
      end

      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (is_msg && (in_src == SRC_WIDTH'(i))) begin
          seen_r[i] <= 1'b1;
          age_r[i]  <= '0;
        end else if (is_tick && (age_r[i] != '1)) begin
          age_r[i]  <= AGE_WIDTH'(age_r[i] + 1'b1);
        end
      end

      if (is_tick) begin
        cur_sel_r   <= pick;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: velocity store and result data
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (is_msg && (in_src == SRC_WIDTH'(i))) begin
        vel_r[i] <= in_tdata;
      end
    end
    if (is_tick) begin
      out_tuser_r <= {(pick != cur_sel_r), pick};
      out_tdata_r <= pick_vel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- hdl/pmt_checker.sv -----
// ----------------------------------------------------------------------------
// pmt_sva
// Port-level checks of the priority mux with timeouts, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_mux_with_timeouts_macros.svh"

module pmt_sva (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [pmt_pkg::IN_TUSER_WIDTH-1:0]   in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [pmt_pkg::OUT_TUSER_WIDTH-1:0]  out_tuser,
  input logic [pmt_pkg::TDATA_WIDTH-1:0]      out_tdata
);

  import pmt_pkg::*;

  logic tick_acc;
  logic msg_acc;
  logic out_free;
  logic out_stall;
  logic none_out;

  assign tick_acc  = in_tvalid && in_tready && (in_tuser[0] == CMD_TICK);
  assign msg_acc   = in_tvalid && in_tready && (in_tuser[0] == CMD_MSG);
  assign out_free  = !out_tvalid || out_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign none_out  = out_tvalid && (out_tuser[SRC_WIDTH-1:0] == SRC_NONE);

  // every accepted tick yields a result in the next cycle
  `PMT_ASSERT_NEXT(a_tick_gives_result, tick_acc, out_tvalid, "tick item gave no result")

  // a message never yields a result of its own
  `PMT_ASSERT_NEXT(a_msg_no_result, msg_acc && out_free, !out_tvalid, "message item made a result")

  // no active source means zero velocities
  `PMT_ASSERT_SAME(a_none_is_zero, none_out, out_tdata == '0, "none selected, velocities nonzero")

  // stalled result holds
  `PMT_ASSERT_NEXT(a_stall_holds, out_stall, out_tvalid && $stable({out_tuser, out_tdata}), "stalled result changed")

endmodule

bind priority_mux_with_timeouts pmt_sva u_pmt_sva (.*);
